>>> hdl/accel_tilt_angles_core_defines.svh
// assertion macros for the tilt angle core
// no dependencies; included by the top level only
`ifndef ACCEL_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_TILT_ANGLES_CORE_DEFINES_SVH

// condition must hold in the same cycle
`define ATILT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tilt core check failed");

// condition must hold in the next cycle
`define ATILT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tilt core check failed");

`endif

>>> hdl/atilt_pkg.sv
// shared constants, widths and arctangent table for the tilt angle core
// no dependencies
`default_nettype none
package atilt_pkg;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int DW = 36;          // cordic x/y datapath width
  localparam int ANG_W = 26;       // angle accumulator, 2^-16 degree
  localparam int PRE_SHIFT = 14;
  localparam int GAIN_Q16 = 107922;
  localparam int HALF_TURN_Q16 = 11796480;
  localparam int ROLL_LIMIT = 23040;
  localparam int PITCH_LIMIT = 11520;

  function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = ANG_W'(2949120);
      1: v = ANG_W'(1740967);
      2: v = ANG_W'(919879);
      3: v = ANG_W'(466945);
      4: v = ANG_W'(234379);
      5: v = ANG_W'(117304);
      6: v = ANG_W'(58666);
      7: v = ANG_W'(29334);
      8: v = ANG_W'(14668);
      9: v = ANG_W'(7334);
      10: v = ANG_W'(3667);
      11: v = ANG_W'(1833);
      12: v = ANG_W'(917);
      13: v = ANG_W'(458);
      14: v = ANG_W'(229);
      15: v = ANG_W'(115);
      16: v = ANG_W'(57);
      17: v = ANG_W'(29);
      18: v = ANG_W'(14);
      19: v = ANG_W'(7);
      20: v = ANG_W'(4);
      21: v = ANG_W'(2);
      22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> hdl/atilt_cordic_stage.sv
// one registered vectoring micro-rotation with sideband
// depends on atilt_pkg
`default_nettype none
module atilt_cordic_stage #(
  parameter int STAGE = 0,
  parameter int SB_W = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_vld,
  input  wire logic signed [atilt_pkg::DW-1:0]    in_x,
  input  wire logic signed [atilt_pkg::DW-1:0]    in_y,
  input  wire logic signed [atilt_pkg::ANG_W-1:0] in_ang,
  input  wire logic [SB_W-1:0]                    in_sb,
  output logic                                    out_vld,
  output logic signed [atilt_pkg::DW-1:0]         out_x,
  output logic signed [atilt_pkg::DW-1:0]         out_y,
  output logic signed [atilt_pkg::ANG_W-1:0]      out_ang,
  output logic [SB_W-1:0]                         out_sb
);
  logic signed [atilt_pkg::DW-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [atilt_pkg::ANG_W-1:0] ang_nxt, ang_r;
  logic [SB_W-1:0] sb_r;
  logic vld_r;

  generate
    if (STAGE < atilt_pkg::TABLE_LEN) begin : g_rot
      always_comb begin
        if (in_y > 0) begin
          x_nxt = in_x + (in_y >>> STAGE);
          y_nxt = in_y - (in_x >>> STAGE);
          ang_nxt = in_ang + atilt_pkg::atan_q16(STAGE);
        end else begin
          x_nxt = in_x - (in_y >>> STAGE);
          y_nxt = in_y + (in_x >>> STAGE);
          ang_nxt = in_ang - atilt_pkg::atan_q16(STAGE);
        end
      end
    end else begin : g_skip
      // no table entry: stage passes data through
      always_comb begin
        x_nxt = in_x;
        y_nxt = in_y;
        ang_nxt = in_ang;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      ang_r <= ang_nxt;
      sb_r <= in_sb;
    end
  end

  assign out_vld = vld_r;
  assign out_x = x_r;
  assign out_y = y_r;
  assign out_ang = ang_r;
  assign out_sb = sb_r;
endmodule
`default_nettype wire

>>> hdl/atilt_cordic.sv
// chain of registered vectoring cordic stages
// depends on atilt_pkg and atilt_cordic_stage
`default_nettype none
module atilt_cordic #(
  parameter int CORDIC_STAGES = atilt_pkg::CORDIC_STAGES_DEF,
  parameter int SB_W = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_vld,
  input  wire logic signed [atilt_pkg::DW-1:0]    in_x,
  input  wire logic signed [atilt_pkg::DW-1:0]    in_y,
  input  wire logic [SB_W-1:0]                    in_sb,
  output logic                                    out_vld,
  output logic signed [atilt_pkg::DW-1:0]         out_x,
  output logic signed [atilt_pkg::ANG_W-1:0]      out_ang,
  output logic [SB_W-1:0]                         out_sb
);
  logic                               vld [CORDIC_STAGES+1];
  logic signed [atilt_pkg::DW-1:0]    xs  [CORDIC_STAGES+1];
  logic signed [atilt_pkg::DW-1:0]    ys  [CORDIC_STAGES+1];
  logic signed [atilt_pkg::ANG_W-1:0] as  [CORDIC_STAGES+1];
  logic [SB_W-1:0]                    sbs [CORDIC_STAGES+1];

  assign vld[0] = in_vld;
  assign xs[0] = in_x;
  assign ys[0] = in_y;
  assign as[0] = '0;
  assign sbs[0] = in_sb;

  generate
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      atilt_cordic_stage #(.STAGE(i), .SB_W(SB_W)) u_stage (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(vld[i]), .in_x(xs[i]), .in_y(ys[i]), .in_ang(as[i]), .in_sb(sbs[i]),
        .out_vld(vld[i+1]), .out_x(xs[i+1]), .out_y(ys[i+1]), .out_ang(as[i+1]),
        .out_sb(sbs[i+1])
      );
    end
  endgenerate

  assign out_vld = vld[CORDIC_STAGES];
  assign out_x = xs[CORDIC_STAGES];
  assign out_ang = as[CORDIC_STAGES];
  assign out_sb = sbs[CORDIC_STAGES];
endmodule
`default_nettype wire

>>> hdl/accel_tilt_angles_core.sv
// tilt core: stage 0 register, roll chain, gain register, pitch chain, output register
// one sample per cycle unless stalled; roll and pitch cordic chains are fully pipelined
// the whole pipeline advances together and freezes only while the output is stalled
// synchronous active-low reset clears all valid bits; data registers are not reset
// depends on atilt_pkg, atilt_cordic and the defines header
`default_nettype none
`include "accel_tilt_angles_core_defines.svh"
module accel_tilt_angles_core #(
  parameter int CORDIC_STAGES = atilt_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // roll_deg[15:0], pitch_deg[30:16], zero [31]
);
  localparam int DW = atilt_pkg::DW;
  localparam int AW = atilt_pkg::ANG_W;
  localparam int SB1_W = 16 + 4;      // accel_x, zero flags, half-turn offset sign pair
  localparam int SB2_W = AW + 2;      // roll angle, zero flags

  // global advance: move when the output register is empty or being drained
  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 0: unpack, half-plane fold, pre-shift ----------------
  logic signed [15:0] ax, ay, az;
  assign ax = in_tdata[15:0];
  assign ay = in_tdata[31:16];
  assign az = in_tdata[47:32];

  logic signed [DW-1:0] x0_nxt, y0_nxt, x0_r, y0_r;
  logic [SB1_W-1:0] sb0_nxt, sb0_r;
  logic v0_r;
  logic zero_yz, zero_all, neg_z;

  always_comb begin
    zero_yz = (ay == 16'sd0) && (az == 16'sd0);
    zero_all = zero_yz && (ax == 16'sd0);
    neg_z = az < 16'sd0;
    x0_nxt = DW'(az) <<< atilt_pkg::PRE_SHIFT;
    y0_nxt = DW'(ay) <<< atilt_pkg::PRE_SHIFT;
    if (neg_z) begin
      // left half plane: negate vector, add or subtract a half turn later
      x0_nxt = -x0_nxt;
      y0_nxt = -y0_nxt;
    end
    // sideband: [15:0] ax, [16] zero_yz, [17] zero_all, [18] offset on, [19] offset negative
    sb0_nxt = {ay < 16'sd0, neg_z, zero_all, zero_yz, ax};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
      sb0_r <= sb0_nxt;
    end
  end

  // ---------------- roll pass ----------------
  logic v1;
  logic signed [DW-1:0] mag1;
  logic signed [AW-1:0] ang1;
  logic [SB1_W-1:0] sb1;

  atilt_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .SB_W(SB1_W)) u_roll (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(v0_r), .in_x(x0_r), .in_y(y0_r), .in_sb(sb0_r),
    .out_vld(v1), .out_x(mag1), .out_ang(ang1), .out_sb(sb1)
  );

  // ---------------- gain stage: scale -x by the cordic gain, fold offset ----------------
  logic signed [16:0] neg_ax;
  logic signed [34:0] gprod;
  logic signed [AW-1:0] roll_ang_nxt;
  logic signed [DW-1:0] mag_r, y2_r;
  logic [SB2_W-1:0] sb2_r;
  logic v2_r;

  always_comb begin
    neg_ax = -(17'(signed'(sb1[15:0])));
    gprod = 35'(neg_ax) * 35'(atilt_pkg::GAIN_Q16);
    roll_ang_nxt = ang1;
    if (sb1[18]) begin
      if (sb1[19]) begin
        roll_ang_nxt = ang1 - AW'(atilt_pkg::HALF_TURN_Q16);
      end else begin
        roll_ang_nxt = ang1 + AW'(atilt_pkg::HALF_TURN_Q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1;
    end
  end

  // -x * 2^14 * gain >> 16 equals the product shifted right by two
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag1;
      y2_r <= DW'(gprod >>> 2);
      sb2_r <= {sb1[17:16], roll_ang_nxt};
    end
  end

  // ---------------- pitch pass ----------------
  logic v3;
  logic signed [DW-1:0] unused_x;
  logic signed [AW-1:0] ang3;
  logic [SB2_W-1:0] sb3;

  atilt_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .SB_W(SB2_W)) u_pitch (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(v2_r), .in_x(mag_r), .in_y(y2_r), .in_sb(sb2_r),
    .out_vld(v3), .out_x(unused_x), .out_ang(ang3), .out_sb(sb3)
  );

  // ---------------- output stage: round half up to 1/128 degree, clamp ----------------
  logic signed [AW-1:0] roll_ang3;
  logic signed [AW-10:0] roll_q, pitch_q;
  logic signed [15:0] roll_nxt, roll_r;
  logic signed [14:0] pitch_nxt, pitch_r;
  logic out_vld_r;

  always_comb begin
    roll_ang3 = sb3[AW-1:0];
    roll_q = (AW-9)'((roll_ang3 + AW'(256)) >>> 9);
    pitch_q = (AW-9)'((ang3 + AW'(256)) >>> 9);
    if (roll_q > (AW-9)'(atilt_pkg::ROLL_LIMIT)) begin
      roll_nxt = 16'(atilt_pkg::ROLL_LIMIT);
    end else if (roll_q < -(AW-9)'(atilt_pkg::ROLL_LIMIT)) begin
      roll_nxt = -16'(atilt_pkg::ROLL_LIMIT);
    end else begin
      roll_nxt = roll_q[15:0];
    end
    if (pitch_q > (AW-9)'(atilt_pkg::PITCH_LIMIT)) begin
      pitch_nxt = 15'(atilt_pkg::PITCH_LIMIT);
    end else if (pitch_q < -(AW-9)'(atilt_pkg::PITCH_LIMIT)) begin
      pitch_nxt = -15'(atilt_pkg::PITCH_LIMIT);
    end else begin
      pitch_nxt = pitch_q[14:0];
    end
    // zero vectors give angle zero instead of a cordic residue
    if (sb3[AW]) begin
      roll_nxt = '0;
    end
    if (sb3[AW+1]) begin
      pitch_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r <= roll_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {1'b0, pitch_r, roll_r};

  // ---------------- checks ----------------
  `ATILT_ASSERT_NOW(a_roll_range, clk, rst_n, out_tvalid,
    ($signed(out_tdata[15:0]) <= 16'sd23040) && ($signed(out_tdata[15:0]) >= -16'sd23040))
  `ATILT_ASSERT_NOW(a_pitch_range, clk, rst_n, out_tvalid,
    ($signed(out_tdata[30:16]) <= 15'sd11520) && ($signed(out_tdata[30:16]) >= -15'sd11520))
  `ATILT_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(v3))
endmodule
`default_nettype wire
